// ===== rtl/scc_pkg.sv =====
// Shared types and constants for the strongly connected components block.
// No dependencies; every other file in rtl/ imports this package.
package scc_pkg;

  localparam int unsigned NODE_W = 7;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] edge_from;
    logic [NODE_W-1:0] edge_to;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] component;
    logic              last;
  } out_item_t;

  // Command handed from the front end to the engine through the queue.
  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] edge_from;
    logic [NODE_W-1:0] edge_to;
  } cmd_t;

  // Engine feedback to the front end.
  typedef struct packed {
    logic pop;
    logic done;
  } back_status_t;

endpackage

// ===== rtl/strongly_connected_components.sv =====
// Strongly connected components of a directed graph (Kosaraju), top level.
// Depends on scc_pkg, scc_front and scc_engine.
//
// Edge items (mode 0) are taken one per cycle while busy_o is low; edges
// with an endpoint of zero or above node_count (clamped to 1..MAX_NODES),
// or arriving with the store full, are dropped. A compute item (mode 1)
// holds busy_o high until its results are out. Each pass reads every stored
// edge from the single-port edge store for each node's frame, a frame
// resuming where it left off. Results appear one per strobe and cannot be
// stalled; the final one carries last. The edge store needs no clearing pass.
module strongly_connected_components #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  scc_pkg::in_item_t          in_i,
  output logic                       res_valid_o,
  output scc_pkg::out_item_t         res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [scc_pkg::NODE_W-1:0] cfg_data_i
);
  import scc_pkg::*;

  logic [NODE_W-1:0] node_count_q;
  logic [NODE_W-1:0] n_eff;
  logic              cmd_valid;
  cmd_t              cmd;
  back_status_t      status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_W'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    priority if (node_count_q == '0) begin
      n_eff = NODE_W'(1);
    end else if (node_count_q > NODE_W'(MAX_NODES)) begin
      n_eff = NODE_W'(MAX_NODES);
    end else begin
      n_eff = node_count_q;
    end
  end

  scc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .n_i         (n_eff),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  scc_engine #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/scc_front.sv =====
// Front end: accepts items, drops edges with bad endpoints, queues commands.
// Depends on scc_pkg.
module scc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  scc_pkg::in_item_t          in_i,
  input  logic [scc_pkg::NODE_W-1:0] n_i,
  output logic                       cmd_valid_o,
  output scc_pkg::cmd_t              cmd_o,
  input  scc_pkg::back_status_t      status_i
);
  import scc_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       run_q;
  logic       accept;
  logic       edge_ok;
  logic       push;
  logic       pop;

  assign busy_o      = (count_q == 2'd2) || run_q;
  assign accept      = start_i && !busy_o;
  assign edge_ok     = (in_i.edge_from != '0) && (in_i.edge_from <= n_i) &&
                       (in_i.edge_to != '0) && (in_i.edge_to <= n_i);
  assign push        = accept && ((in_i.mode == MODE_RUN) || edge_ok);
  assign pop         = status_i.pop && (count_q != 2'd0);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{mode: in_i.mode, edge_from: in_i.edge_from,
                            edge_to: in_i.edge_to};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      run_q    <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
      // hold off new items from compute accept until the engine finishes
      if (accept && (in_i.mode == MODE_RUN)) begin
        run_q <= 1'b1;
      end else if (status_i.done) begin
        run_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/scc_engine.sv =====
// Back end: edge store, the two depth-first passes and result emission.
// Depends on scc_pkg.
module scc_engine #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [scc_pkg::NODE_W-1:0] n_i,
  input  logic                       cmd_valid_i,
  input  scc_pkg::cmd_t              cmd_i,
  output scc_pkg::back_status_t      status_o,
  output logic                       res_valid_o,
  output scc_pkg::out_item_t         res_o
);
  import scc_pkg::*;

  localparam int unsigned NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned DW  = $clog2(MAX_NODES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_P1, ST_P2_NEXT, ST_P2_GET, ST_SCAN_RD, ST_SCAN_CHK, ST_POP, ST_DONE
  } state_e;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [ECW-1:0]    cursor;
  } frame_t;

  logic [2*NODE_W-1:0] edge_mem [MAX_EDGES];
  frame_t              ws_mem   [MAX_NODES];
  logic [NODE_W-1:0]   fs_mem   [MAX_NODES];

  logic [2*NODE_W-1:0] edge_rd_q;
  frame_t              ws_rd_q;
  logic [NODE_W-1:0]   fs_rd_q;

  state_e              state_q;
  logic                pass_q;
  logic [NODE_W:0]     i_q;
  logic [NODE_W-1:0]   node_q;
  logic [ECW-1:0]      cur_q;
  logic [DW-1:0]       depth_q;
  logic [DW-1:0]       ftop_q;
  logic [ECW-1:0]      total_q;
  logic [NODE_W-1:0]   comp_q;
  logic [MAX_NODES-1:0] seen_q;
  logic                pend_valid_q;
  logic [NODE_W-1:0]   pend_node_q;
  logic [NODE_W-1:0]   pend_comp_q;
  logic                res_valid_q;
  out_item_t           res_q;

  logic                edge_we, edge_re;
  logic [EAW-1:0]      edge_raddr;
  logic                ws_we, ws_re;
  logic [NIW-1:0]      ws_waddr, ws_raddr;
  logic                fs_we, fs_re;
  logic [NIW-1:0]      fs_waddr, fs_raddr;

  logic [NODE_W-1:0]   a_node, b_node, b_less, i_less, u_less;
  logic [DW-1:0]       depth_m1, depth_m2, ftop_m1;
  logic                hit;
  logic                emit_en;
  logic [NODE_W-1:0]   emit_node, emit_comp;

  assign a_node   = pass_q ? edge_rd_q[NODE_W-1:0] : edge_rd_q[2*NODE_W-1:NODE_W];
  assign b_node   = pass_q ? edge_rd_q[2*NODE_W-1:NODE_W] : edge_rd_q[NODE_W-1:0];
  assign b_less   = b_node - NODE_W'(1);
  assign i_less   = i_q[NODE_W-1:0] - NODE_W'(1);
  assign u_less   = fs_rd_q - NODE_W'(1);
  assign depth_m1 = depth_q - DW'(1);
  assign depth_m2 = depth_q - DW'(2);
  assign ftop_m1  = ftop_q - DW'(1);
  assign hit      = (a_node == node_q) && (b_node != '0) && (b_node <= n_i) &&
                    !seen_q[b_less[NIW-1:0]];

  assign status_o.pop  = (state_q == ST_IDLE);
  assign status_o.done = (state_q == ST_DONE);
  assign res_valid_o   = res_valid_q;
  assign res_o         = res_q;

  always_comb begin
    edge_we    = 1'b0;
    edge_re    = 1'b0;
    edge_raddr = cur_q[EAW-1:0];
    ws_we      = 1'b0;
    ws_re      = 1'b0;
    ws_waddr   = depth_m1[NIW-1:0];
    ws_raddr   = depth_m2[NIW-1:0];
    fs_we      = 1'b0;
    fs_re      = 1'b0;
    fs_waddr   = ftop_q[NIW-1:0];
    fs_raddr   = ftop_m1[NIW-1:0];
    emit_en    = 1'b0;
    emit_node  = b_node;
    emit_comp  = comp_q;
    unique case (state_q)
      ST_IDLE: begin
        edge_we = cmd_valid_i && (cmd_i.mode == MODE_ADD) && (total_q < ECW'(MAX_EDGES));
      end
      ST_P2_NEXT: fs_re = (ftop_q != '0);
      ST_P2_GET: begin
        emit_en   = !seen_q[u_less[NIW-1:0]];
        emit_node = fs_rd_q;
        emit_comp = comp_q + NODE_W'(1);
      end
      ST_SCAN_RD: begin
        if (cur_q < total_q) begin
          edge_re = 1'b1;
        end else begin
          fs_we = !pass_q;
          ws_re = (depth_q > DW'(1));
        end
      end
      ST_SCAN_CHK: begin
        ws_we   = hit;
        emit_en = hit && pass_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[total_q[EAW-1:0]] <= {cmd_i.edge_from, cmd_i.edge_to};
    if (edge_re) edge_rd_q <= edge_mem[edge_raddr];
    if (ws_we) ws_mem[ws_waddr] <= '{node: node_q, cursor: cur_q};
    if (ws_re) ws_rd_q <= ws_mem[ws_raddr];
    if (fs_we) fs_mem[fs_waddr] <= node_q;
    if (fs_re) fs_rd_q <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pass_q       <= 1'b0;
      i_q          <= '0;
      node_q       <= '0;
      cur_q        <= '0;
      depth_q      <= '0;
      ftop_q       <= '0;
      total_q      <= '0;
      comp_q       <= '0;
      seen_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_node_q  <= '0;
      pend_comp_q  <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.mode == MODE_ADD) begin
              if (total_q < ECW'(MAX_EDGES)) total_q <= total_q + ECW'(1);
            end else begin
              seen_q  <= '0;
              ftop_q  <= '0;
              pass_q  <= 1'b0;
              i_q     <= (NODE_W+1)'(1);
              state_q <= ST_P1;
            end
          end
        end
        ST_P1: begin
          if (i_q > {1'b0, n_i}) begin
            seen_q  <= '0;
            comp_q  <= '0;
            pass_q  <= 1'b1;
            state_q <= ST_P2_NEXT;
          end else if (seen_q[i_less[NIW-1:0]]) begin
            i_q <= i_q + (NODE_W+1)'(1);
          end else begin
            seen_q[i_less[NIW-1:0]] <= 1'b1;
            node_q  <= i_q[NODE_W-1:0];
            cur_q   <= '0;
            depth_q <= DW'(1);
            state_q <= ST_SCAN_RD;
          end
        end
        ST_P2_NEXT: begin
          if (ftop_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            ftop_q  <= ftop_m1;
            state_q <= ST_P2_GET;
          end
        end
        ST_P2_GET: begin
          if (emit_en) begin
            comp_q  <= emit_comp;
            seen_q[u_less[NIW-1:0]] <= 1'b1;
            node_q  <= fs_rd_q;
            cur_q   <= '0;
            depth_q <= DW'(1);
            state_q <= ST_SCAN_RD;
          end else begin
            state_q <= ST_P2_NEXT;
          end
        end
        ST_SCAN_RD: begin
          if (cur_q < total_q) begin
            cur_q   <= cur_q + ECW'(1);
            state_q <= ST_SCAN_CHK;
          end else begin
            // frame exhausted: finish it and drop back to the parent
            if (!pass_q) ftop_q <= ftop_q + DW'(1);
            depth_q <= depth_m1;
            if (depth_q == DW'(1)) begin
              state_q <= pass_q ? ST_P2_NEXT : ST_P1;
            end else begin
              state_q <= ST_POP;
            end
          end
        end
        ST_SCAN_CHK: begin
          if (hit) begin
            seen_q[b_less[NIW-1:0]] <= 1'b1;
            node_q  <= b_node;
            cur_q   <= '0;
            depth_q <= depth_q + DW'(1);
          end
          state_q <= ST_SCAN_RD;
        end
        ST_POP: begin
          node_q  <= ws_rd_q.node;
          cur_q   <= ws_rd_q.cursor;
          state_q <= ST_SCAN_RD;
        end
        ST_DONE: begin
          if (pend_valid_q) begin
            res_valid_q  <= 1'b1;
            res_q        <= '{node: pend_node_q, component: pend_comp_q, last: 1'b1};
            pend_valid_q <= 1'b0;
          end
          total_q <= '0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      // keep one result back so the final one can carry last
      if (emit_en) begin
        if (pend_valid_q) begin
          res_valid_q <= 1'b1;
          res_q       <= '{node: pend_node_q, component: pend_comp_q, last: 1'b0};
        end
        pend_valid_q <= 1'b1;
        pend_node_q  <= emit_node;
        pend_comp_q  <= emit_comp;
      end
    end
  end

endmodule

// ===== rtl/scc_checker.sv =====
// Port-level checks for strongly_connected_components, attached by bind.
// Depends on scc_pkg.
module scc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input scc_pkg::in_item_t  in_i,
  input logic               res_valid_o,
  input scc_pkg::out_item_t res_o
);
  import scc_pkg::*;

  // a compute item locks out further items
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (in_i.mode == MODE_RUN) |=> busy_o)
    else $error("busy not raised after compute item");

  // nothing follows the final result of a run
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("result after last");

  // node and component numbers start from one
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.node != '0) && (res_o.component != '0))
    else $error("zero node or component");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .in_i        (in_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
